[rtl/lcd4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, command codes and init tables for the 4-bit LCD sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

   // input command codes
   localparam logic [1:0] FUNC_INIT   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [1:0] FUNC_CURSOR = 2'd3;

   // classified command kinds
   localparam logic [2:0] KIND_INIT   = 3'd0;
   localparam logic [2:0] KIND_WRITE  = 3'd1;
   localparam logic [2:0] KIND_CLEAR  = 3'd2;
   localparam logic [2:0] KIND_CURSOR = 3'd3;
   localparam logic [2:0] KIND_REJECT = 3'd4;

   // step within one nibble
   localparam logic [1:0] PH_SET   = 2'd0;
   localparam logic [1:0] PH_EN_HI = 2'd1;
   localparam logic [1:0] PH_EN_LO = 2'd2;
   localparam logic [1:0] PH_CLOSE = 2'd3;

   localparam logic [7:0] CURSOR_LIMIT = 8'h67;
   localparam logic [7:0] CURSOR_FLAG  = 8'h80;

   // clear display instruction byte
   localparam logic [7:0] CLEAR_BYTE   = 8'h01;

   localparam logic [3:0] INIT_LAST_IDX = 4'd10;
   localparam logic [3:0] BYTE_LAST_IDX = 4'd1;

   localparam logic [15:0] WAIT_CMD        = 16'd40;
   localparam logic [15:0] WAIT_STROBE     = 16'd1;
   localparam logic [15:0] WAIT_INIT_CLOSE = 16'd10000;
   localparam logic [15:0] WAIT_CLEAR      = 16'd2000;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [3:0] init_nibble(input logic [3:0] idx);
      logic [3:0] n;
      case (idx)
         4'd0:    n = 4'h3;
         4'd1:    n = 4'h2;
         4'd2:    n = 4'h8;
         4'd3:    n = 4'h2;
         4'd4:    n = 4'h8;
         4'd5:    n = 4'h0;
         4'd6:    n = 4'hF;
         4'd7:    n = 4'h0;
         4'd8:    n = 4'h1;
         4'd9:    n = 4'h0;
         4'd10:   n = 4'h6;
         default: n = 4'h0;
      endcase
      return n;
   endfunction

   function automatic logic [15:0] init_wait(input logic [3:0] idx);
      logic [15:0] w;
      case (idx)
         4'd0:                w = 16'd50000;
         4'd1, 4'd3, 4'd5,
         4'd7:                w = 16'd40;
         4'd9:                w = 16'd2000;
         default:             w = 16'd0;
      endcase
      return w;
   endfunction

endpackage

[rtl/lcd4_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_front
// Classifies an incoming command word and range-checks the cursor position.
// ----------------------------------------------------------------------------
module lcd4_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_data_byte,
   output logic              push,
   output lcd4_pkg::cmd_type push_cmd,
   input  logic              q_full
);
   import lcd4_pkg::*;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_cmd.data = req_data_byte;
      case (req_func)
         FUNC_INIT:  push_cmd.kind = KIND_INIT;
         FUNC_WRITE: push_cmd.kind = KIND_WRITE;
         FUNC_CLEAR: begin
            // clear sends a fixed instruction byte, data_byte is ignored
            push_cmd.kind = KIND_CLEAR;
            push_cmd.data = CLEAR_BYTE;
         end
         FUNC_CURSOR: begin
            if (req_data_byte >= CURSOR_LIMIT) begin
               push_cmd.kind = KIND_REJECT;
            end else begin
               push_cmd.kind = KIND_CURSOR;
               push_cmd.data = req_data_byte | CURSOR_FLAG;
            end
         end
         default:    push_cmd.kind = KIND_INIT;
      endcase
   end

endmodule

[rtl/lcd4_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module lcd4_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcd4_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output lcd4_pkg::cmd_type head_cmd
);
   import lcd4_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/lcd4_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_back
// Steps through nibbles and strobe phases of one command, one pin word per
// cycle while the output stage is free, into a registered output stage.
// ----------------------------------------------------------------------------
module lcd4_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  lcd4_pkg::cmd_type q_head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_wait_us,
   output logic              rsp_reg_select,
   output logic              rsp_enable,
   output logic [3:0]        rsp_nibble,
   output logic              rsp_rejected,
   output logic              rsp_last
);
   import lcd4_pkg::*;

   cmd_type    cmd_ff, cmd_in;
   logic       busy_ff, busy_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] phase_ff, phase_in;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_wait_ff, out_wait_in;
   logic        out_rs_ff, out_rs_in;
   logic        out_en_ff, out_en_in;
   logic [3:0]  out_nib_ff, out_nib_in;
   logic        out_rej_ff, out_rej_in;
   logic        out_last_ff, out_last_in;

   logic        out_free, emit, is_last;
   logic [3:0]  last_idx;
   logic [3:0]  cur_nib;
   logic [15:0] set_wait, close_wait;

   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign last_idx = (cmd_ff.kind == KIND_INIT) ? INIT_LAST_IDX : BYTE_LAST_IDX;

   always_comb begin
      if (cmd_ff.kind == KIND_INIT) begin
         cur_nib  = init_nibble(idx_ff);
         set_wait = init_wait(idx_ff);
      end else begin
         cur_nib  = (idx_ff == 4'd0) ? cmd_ff.data[7:4] : cmd_ff.data[3:0];
         set_wait = (idx_ff == 4'd0) ? WAIT_CMD : 16'd0;
      end
      case (cmd_ff.kind)
         KIND_INIT:  close_wait = WAIT_INIT_CLOSE;
         KIND_CLEAR: close_wait = WAIT_CLEAR;
         default:    close_wait = WAIT_CMD;
      endcase
   end

   always_comb begin
      case (cmd_ff.kind)
         KIND_REJECT: is_last = 1'b1;
         KIND_WRITE:  is_last = (phase_ff == PH_EN_LO) && (idx_ff == last_idx);
         default:     is_last = (phase_ff == PH_CLOSE);
      endcase
   end

   assign pop = q_not_empty && (!busy_ff || (emit && is_last));

   // sequencer
   always_comb begin
      cmd_in   = cmd_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      if (emit) begin
         case (phase_ff)
            PH_SET:   phase_in = PH_EN_HI;
            PH_EN_HI: phase_in = PH_EN_LO;
            PH_EN_LO: begin
               if (idx_ff == last_idx) begin
                  phase_in = PH_CLOSE;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  phase_in = PH_SET;
               end
            end
            default:  phase_in = PH_CLOSE;
         endcase
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         cmd_in   = q_head;
         busy_in  = 1'b1;
         idx_in   = 4'd0;
         phase_in = PH_SET;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_wait_in  = out_wait_ff;
      out_rs_in    = out_rs_ff;
      out_en_in    = out_en_ff;
      out_nib_in   = out_nib_ff;
      out_rej_in   = out_rej_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = is_last;
         if (cmd_ff.kind == KIND_REJECT) begin
            out_wait_in = 16'd0;
            out_rs_in   = 1'b0;
            out_en_in   = 1'b0;
            out_nib_in  = 4'd0;
            out_rej_in  = 1'b1;
         end else begin
            out_rs_in  = (cmd_ff.kind == KIND_WRITE);
            out_en_in  = (phase_ff == PH_EN_HI);
            out_nib_in = cur_nib;
            out_rej_in = 1'b0;
            case (phase_ff)
               PH_SET:   out_wait_in = set_wait;
               PH_EN_HI: out_wait_in = 16'd0;
               PH_EN_LO: out_wait_in = WAIT_STROBE;
               default:  out_wait_in = close_wait;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      phase_ff    <= phase_in;
      out_wait_ff <= out_wait_in;
      out_rs_ff   <= out_rs_in;
      out_en_ff   <= out_en_in;
      out_nib_ff  <= out_nib_in;
      out_rej_ff  <= out_rej_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_wait_us    = out_wait_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_enable     = out_en_ff;
   assign rsp_nibble     = out_nib_ff;
   assign rsp_rejected   = out_rej_ff;
   assign rsp_last       = out_last_ff;

endmodule

[rtl/lcd_4bit_command_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_4bit_command_sequencer_top
// Turns LCD commands into timed pin words for a 4-bit character-LCD bus.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one command word (func, data_byte) per valid/ready handshake.
//   rsp_*  : the pin words of that command, in order, one per handshake;
//            rsp_last marks the final word of each command.
//   Init yields 34 words, write 6, clear and cursor 7, a bad cursor 1.
//   A taken command reaches the pins through the queue, the sequencer's
//   command register and then the output register.
//   Throughput: one word per cycle from the back-end sequencer while
//   rsp_ready does not stall it; a queued next command starts the cycle
//   after the previous last word is issued.
//   A two-entry queue holds commands while the sequencer is busy; req_ready
//   drops only when it is full.
//   When rsp_ready is low a pending output word holds and the sequencer waits.
//   Reset empties the queue and output stage; no state survives commands.
// ----------------------------------------------------------------------------
module lcd_4bit_command_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_wait_us,
   output logic        rsp_reg_select,
   output logic        rsp_enable,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_rejected,
   output logic        rsp_last
);
   import lcd4_pkg::*;

   logic    push, q_full, pop, q_not_empty;
   cmd_type push_cmd, head_cmd;

   lcd4_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_cmd      (push_cmd),
      .q_full        (q_full)
   );

   lcd4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   lcd4_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_wait_us    (rsp_wait_us),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_nibble     (rsp_nibble),
      .rsp_rejected   (rsp_rejected),
      .rsp_last       (rsp_last)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4-bit LCD command sequencer. Directed commands,
// then random bursts, are sent; a scoreboard expands each accepted command into
// its pin words and checks every result word, in order, against them.
// ----------------------------------------------------------------------------
module testbench;
   import lcd4_pkg::*;

   localparam int NUM_RANDOM    = 500;
   localparam int PAUSE_AT      = 250;
   localparam int IDLE_LIMIT    = 2000;
   localparam int TAIL_CYCLES   = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [15:0] delay_us;
      logic        rs;
      logic        en;
      logic [3:0]  nib;
      logic        rej;
      logic        is_last;
   } pin_word_type;

   class lcd_scoreboard;
      pin_word_type pending[$];
      int           faults;

      function void push_word(logic [15:0] dly, logic rs, logic en, logic [3:0] nib,
                              logic rej, logic fin);
         pin_word_type w;
         w.delay_us = dly;
         w.rs       = rs;
         w.en       = en;
         w.nib      = nib;
         w.rej      = rej;
         w.is_last  = fin;
         pending.push_back(w);
      endfunction

      // set, strobe high, strobe low after 1 us
      function void push_nibble(logic [15:0] dly, logic rs, logic [3:0] nib, logic fin);
         push_word(dly, rs, 1'b0, nib, 1'b0, 1'b0);
         push_word(16'd0, rs, 1'b1, nib, 1'b0, 1'b0);
         push_word(16'd1, rs, 1'b0, nib, 1'b0, fin);
      endfunction

      function void note_command(logic [1:0] func, logic [7:0] data_byte);
         logic [3:0]  init_seq [0:10];
         logic [15:0] init_gap [0:10];
         logic [7:0]  pos;
         int          i;
         init_seq = '{4'h3, 4'h2, 4'h8, 4'h2, 4'h8, 4'h0, 4'hF, 4'h0, 4'h1, 4'h0, 4'h6};
         init_gap = '{16'd50000, 16'd40, 16'd0, 16'd40, 16'd0, 16'd40, 16'd0,
                      16'd40, 16'd0, 16'd2000, 16'd0};
         case (func)
            FUNC_INIT: begin
               for (i = 0; i < 11; i++)
                  push_nibble(init_gap[i], 1'b0, init_seq[i], 1'b0);
               push_word(16'd10000, 1'b0, 1'b0, init_seq[10], 1'b0, 1'b1);
            end
            FUNC_WRITE: begin
               push_nibble(16'd40, 1'b1, data_byte[7:4], 1'b0);
               push_nibble(16'd0, 1'b1, data_byte[3:0], 1'b1);
            end
            FUNC_CLEAR: begin
               push_nibble(16'd40, 1'b0, 4'h0, 1'b0);
               push_nibble(16'd0, 1'b0, 4'h1, 1'b0);
               push_word(16'd2000, 1'b0, 1'b0, 4'h1, 1'b0, 1'b1);
            end
            default: begin
               if (data_byte >= 8'h67) begin
                  push_word(16'd0, 1'b0, 1'b0, 4'h0, 1'b1, 1'b1);
               end else begin
                  pos = data_byte | 8'h80;
                  push_nibble(16'd40, 1'b0, pos[7:4], 1'b0);
                  push_nibble(16'd0, 1'b0, pos[3:0], 1'b0);
                  push_word(16'd40, 1'b0, 1'b0, pos[3:0], 1'b0, 1'b1);
               end
            end
         endcase
      endfunction

      function void check_word(pin_word_type got);
         pin_word_type want;
         if (pending.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("unexpected word: delay=%0d rs=%0b en=%0b nib=%h rej=%0b last=%0b",
                        got.delay_us, got.rs, got.en, got.nib, got.rej, got.is_last);
            return;
         end
         want = pending.pop_front();
         if (got.delay_us !== want.delay_us || got.rs !== want.rs || got.en !== want.en ||
             got.nib !== want.nib || got.rej !== want.rej || got.is_last !== want.is_last)
         begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("mismatch: exp delay=%0d rs=%0b en=%0b nib=%h rej=%0b last=%0b",
                        want.delay_us, want.rs, want.en, want.nib, want.rej, want.is_last);
               $display("          got delay=%0d rs=%0b en=%0b nib=%h rej=%0b last=%0b",
                        got.delay_us, got.rs, got.en, got.nib, got.rej, got.is_last);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_wait_us;
   logic        rsp_reg_select;
   logic        rsp_enable;
   logic [3:0]  rsp_nibble;
   logic        rsp_rejected;
   logic        rsp_last;

   lcd_scoreboard board;
   int            idle_cycles;

   lcd_4bit_command_sequencer_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_wait_us    (rsp_wait_us),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_nibble     (rsp_nibble),
      .rsp_rejected   (rsp_rejected),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // valid is raised here and only lowered by idle_for / wait_drained
   task automatic send_command(logic [1:0] func, logic [7:0] data_byte);
      req_valid     <= 1'b1;
      req_func      <= func;
      req_data_byte <= data_byte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(func, data_byte);
   endtask

   task automatic idle_for(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      int          pick;
      logic [1:0]  func;
      logic [7:0]  data_byte;
      pick      = $urandom_range(0, 99);
      data_byte = 8'($urandom_range(0, 255));
      if (pick < 10)
         func = FUNC_INIT;
      else if (pick < 55)
         func = FUNC_WRITE;
      else if (pick < 70)
         func = FUNC_CLEAR;
      else begin
         func = FUNC_CURSOR;
         // mostly legal positions, some refused ones
         if ($urandom_range(0, 4) != 0)
            data_byte = 8'($urandom_range(0, 8'h66));
         else
            data_byte = 8'($urandom_range(8'h67, 8'hFF));
      end
      send_command(func, data_byte);
   endtask

   // receiver: checks words and stalls in changing modes
   initial begin : rx_side
      int mode;
      int span;
      int phase;
      pin_word_type got;
      rsp_ready <= 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            if (!reset && rsp_valid && rsp_ready) begin
               got.delay_us = rsp_wait_us;
               got.rs       = rsp_reg_select;
               got.en       = rsp_enable;
               got.nib      = rsp_nibble;
               got.rej      = rsp_rejected;
               got.is_last  = rsp_last;
               board.check_word(got);
            end
            phase++;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_ready <= (phase % 3 != 0);
               default: rsp_ready <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[lcd_4bit_command_sequencer_top] ERROR");
            $finish;
         end
      end
   end

   initial begin : main
      int sent;
      int burst;
      int gap;
      board         = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_INIT;
      req_data_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command, data extremes, cursor boundary
      send_command(FUNC_INIT, 8'h00);
      send_command(FUNC_WRITE, 8'h00);
      send_command(FUNC_WRITE, 8'hFF);
      send_command(FUNC_WRITE, 8'hA5);
      send_command(FUNC_WRITE, 8'h5A);
      send_command(FUNC_CLEAR, 8'h00);
      send_command(FUNC_CURSOR, 8'h00);
      send_command(FUNC_CURSOR, 8'h66);
      send_command(FUNC_CURSOR, 8'h67);
      send_command(FUNC_CURSOR, 8'hFF);
      send_command(FUNC_CURSOR, 8'h80);
      send_command(FUNC_CURSOR, 8'h40);
      send_command(FUNC_CURSOR, 8'h0F);
      send_command(FUNC_CURSOR, 8'h59);
      send_command(FUNC_INIT, 8'hFF);
      send_command(FUNC_CLEAR, 8'hFF);
      idle_for(3);

      sent = 0;
      while (sent < NUM_RANDOM) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (sent < NUM_RANDOM) begin
               send_random();
               sent++;
               if (sent == PAUSE_AT)
                  wait_drained();
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap != 0)
            idle_for(gap);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending.size() != 0) begin
         board.faults++;
         $display("%0d expected words never arrived", board.pending.size());
      end
      if (board.faults == 0)
         $display("[lcd_4bit_command_sequencer_top] OK");
      else
         $display("[lcd_4bit_command_sequencer_top] ERROR");
      $finish;
   end

endmodule
